FILE: hw/rtl/csp_pkg.sv
// ============================================================================
// csp_pkg: shared types and constants for the compass sentence parser
// Character codes of the sentence grammar and the request format of the
// shared multiply-add unit.
// ============================================================================
package csp_pkg;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [6:0] MUL_TEN     = 7'd10;
  localparam logic [6:0] MUL_HUNDRED = 7'd100;
  localparam logic [6:0] MUL_ONE     = 7'd1;

  typedef enum logic [2:0] {
    OP_MUL10_ADD = 3'd0,  // acc * 10 + digit
    OP_MUL100    = 3'd1,  // acc * 100
    OP_TENTHS    = 3'd2,  // digit * 10 + acc
    OP_ADD       = 3'd3,  // acc + digit
    OP_NEG       = 3'd4   // two's complement of acc
  } mac_op_t;

  typedef struct packed {
    mac_op_t    op;
    logic [3:0] digit;
  } mac_req_t;

endpackage

FILE: hw/rtl/csp_mac.sv
// ============================================================================
// csp_mac: shared multiply-add unit
// Computes a * m + b modulo 2^32, operands picked from the request code.
// ============================================================================
module csp_mac (
  input  csp_pkg::mac_req_t req,
  input  logic [31:0]       acc,
  output logic [31:0]       y
);

  logic [31:0] a;
  logic [6:0]  m;
  logic [31:0] b;
  logic [38:0] prod;

  always_comb begin
    a = acc;
    m = csp_pkg::MUL_ONE;
    b = '0;
    unique case (req.op)
      csp_pkg::OP_MUL10_ADD: begin
        m = csp_pkg::MUL_TEN;
        b = {28'd0, req.digit};
      end
      csp_pkg::OP_MUL100: begin
        m = csp_pkg::MUL_HUNDRED;
      end
      csp_pkg::OP_TENTHS: begin
        a = {28'd0, req.digit};
        m = csp_pkg::MUL_TEN;
        b = acc;
      end
      csp_pkg::OP_ADD: begin
        b = {28'd0, req.digit};
      end
      csp_pkg::OP_NEG: begin
        a = ~acc;
        b = 32'd1;
      end
      default: begin
        a = acc;
      end
    endcase
  end

  assign prod = {7'd0, a} * {32'd0, m};
  assign y    = prod[31:0] + b;

endmodule

FILE: hw/rtl/csp_term_buf.sv
// ============================================================================
// csp_term_buf: term character store
// One write port and one read port with registered read data.
// ============================================================================
module csp_term_buf #(
  parameter int DEPTH = 14,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [7:0]       rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // addresses past the end are never consumed
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/compass_sentence_parser_core.sv
// ============================================================================
// compass_sentence_parser_core: comma-separated compass sentence parser
// Gathers characters into terms and turns heading, pitch and roll terms into
// hundredths of a degree, committed at the end of a sentence.
// ============================================================================
// One item is one received character with its millisecond timestamp. Each
// item gives exactly one result item carrying the committed heading, pitch
// and roll, a has_data flag, the data age and a sentence_done pulse.
// Ordinary characters, '#' and '*' go from acceptance straight to the
// output state. Terminators that parse nothing, commits included, pass
// through the store state first. A comma, CR or LF that closes a heading,
// pitch or roll term of an angle sentence walks the stored term one
// character per cycle through a single shared multiply-add unit until the
// number ends, scales it if it ended in its integer part, applies the sign,
// stores it and loads the result. The input is held off (in_stall high)
// from acceptance until the result is loaded, so the next item can enter
// only once the load is done. A result that waits on out_stall does not
// block the next item from entering; that item's result waits in turn.
// Characters past TERM_LEN-1 in one term are dropped.
module compass_sentence_parser_core #(
  parameter int TERM_LEN = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         ch,
  input  logic [31:0]        now_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               sentence_done,
  output logic signed [31:0] heading,
  output logic signed [31:0] pitch,
  output logic signed [31:0] roll,
  output logic               has_data,
  output logic [31:0]        age_ms
);

  localparam int BUF_LEN = TERM_LEN - 1;
  localparam int LEN_W   = $clog2(TERM_LEN);
  localparam int IDX_W   = $clog2(BUF_LEN);
  localparam logic [LEN_W-1:0] BUF_LEN_L = LEN_W'(BUF_LEN);
  localparam logic [1:0] IDX_MAX = 2'd3;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_SCALE = 6'b000100,
    S_NEG   = 6'b001000,
    S_STORE = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  typedef enum logic [3:0] {
    PH_SIGN  = 4'b0001,
    PH_INT   = 4'b0010,
    PH_FRAC1 = 4'b0100,
    PH_FRAC2 = 4'b1000
  } phase_t;

  state_t state;
  phase_t phase;

  // sentence state
  logic [LEN_W-1:0] term_length;
  logic [1:0]       term_index;
  logic             is_angle;
  logic             after_cr;
  logic [31:0]      pending_head;
  logic [31:0]      pending_pitch;
  logic [31:0]      pending_roll;
  logic [31:0]      pending_time;
  logic             pending_time_valid;
  logic [31:0]      committed_head;
  logic [31:0]      committed_pitch;
  logic [31:0]      committed_roll;
  logic [31:0]      committed_time;
  logic             committed_time_valid;

  // per-item working registers
  logic [7:0]       ch_q;
  logic [31:0]      now_q;
  logic             done_q;
  logic             parsed;
  logic             neg;
  logic [LEN_W-1:0] pos;
  logic [31:0]      acc;

  logic             accept;
  logic             is_term;
  logic             is_restart;
  logic [7:0]       rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic [LEN_W-1:0] pos_inc;
  logic             is_dig;
  logic             eff_int;
  logic             scan_end;
  csp_pkg::mac_req_t mac_req;
  logic [31:0]      mac_y;

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign is_term    = (ch == csp_pkg::CH_COMMA) || (ch == csp_pkg::CH_CR) ||
                      (ch == csp_pkg::CH_LF);
  assign is_restart = (ch == csp_pkg::CH_HASH) || (ch == csp_pkg::CH_STAR);

  assign pos_inc  = pos + 1'b1;
  assign is_dig   = (rd_data >= csp_pkg::CH_ZERO) && (rd_data <= csp_pkg::CH_NINE);
  assign eff_int  = (phase == PH_INT) ||
                    ((phase == PH_SIGN) && (rd_data != csp_pkg::CH_MINUS));
  // term ends at its stored length or at a NUL byte
  assign scan_end = (pos == term_length) || (rd_data == csp_pkg::CH_NUL);

  csp_term_buf #(
    .DEPTH (BUF_LEN),
    .IDX_W (IDX_W)
  ) u_buf (
    .clk     (clk),
    .wr_en   (accept && !is_term && !is_restart && (term_length < BUF_LEN_L)),
    .wr_addr (term_length[IDX_W-1:0]),
    .wr_data (ch),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  csp_mac u_mac (
    .req (mac_req),
    .acc (acc),
    .y   (mac_y)
  );

  // Pick the read address and the shared unit's operation. In idle the
  // first character is fetched so that a scan can start straight away.
  always_comb begin
    rd_addr = '0;
    mac_req = '{op: csp_pkg::OP_ADD, digit: rd_data[3:0]};
    unique case (state)
      S_SCAN: begin
        rd_addr = pos_inc[IDX_W-1:0];
        if (eff_int) begin
          mac_req.op = is_dig ? csp_pkg::OP_MUL10_ADD : csp_pkg::OP_MUL100;
        end else if (phase == PH_FRAC1) begin
          mac_req.op = csp_pkg::OP_TENTHS;
        end else begin
          mac_req.op = csp_pkg::OP_ADD;
        end
      end
      S_SCALE: mac_req.op = csp_pkg::OP_MUL100;
      S_NEG:   mac_req.op = csp_pkg::OP_NEG;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      phase                <= PH_SIGN;
      out_valid            <= 1'b0;
      term_length          <= '0;
      term_index           <= '0;
      is_angle             <= 1'b0;
      after_cr             <= 1'b0;
      pending_head         <= '0;
      pending_pitch        <= '0;
      pending_roll         <= '0;
      pending_time         <= '0;
      pending_time_valid   <= 1'b0;
      committed_head       <= '0;
      committed_pitch      <= '0;
      committed_roll       <= '0;
      committed_time       <= '0;
      committed_time_valid <= 1'b0;
    end else begin
      // drop the result once taken; the output state reloads it itself
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            ch_q   <= ch;
            now_q  <= now_ms;
            done_q <= 1'b0;
            parsed <= 1'b0;
            if (is_term) begin
              if (after_cr) begin
                // commit without parsing the closed term
                committed_time       <= pending_time;
                committed_time_valid <= pending_time_valid;
                if (is_angle) begin
                  committed_head  <= pending_head;
                  committed_pitch <= pending_pitch;
                  committed_roll  <= pending_roll;
                end
                done_q <= 1'b1;
                state  <= S_STORE;
              end else if (is_angle && (term_length != '0) &&
                           (term_index != IDX_MAX)) begin
                pos    <= '0;
                acc    <= '0;
                neg    <= 1'b0;
                phase  <= PH_SIGN;
                parsed <= 1'b1;
                state  <= S_SCAN;
              end else begin
                state <= S_STORE;
              end
            end else if (is_restart) begin
              term_length <= '0;
              term_index  <= '0;
              is_angle    <= 1'b0;
              after_cr    <= 1'b0;
              state       <= S_OUT;
            end else begin
              if (ch == csp_pkg::CH_DOT) begin
                is_angle <= 1'b1;
              end
              if (term_length < BUF_LEN_L) begin
                term_length <= term_length + 1'b1;
              end
              state <= S_OUT;
            end
          end
        end

        S_SCAN: begin
          if (scan_end) begin
            if (pos == '0) begin
              parsed <= 1'b0;
              state  <= S_STORE;
            end else if (eff_int) begin
              state <= S_SCALE;
            end else begin
              state <= S_NEG;
            end
          end else begin
            pos <= pos_inc;
            if ((phase == PH_SIGN) && (rd_data == csp_pkg::CH_MINUS)) begin
              neg   <= 1'b1;
              phase <= PH_INT;
            end else if (eff_int) begin
              acc <= mac_y;
              if (is_dig) begin
                phase <= PH_INT;
              end else if (rd_data == csp_pkg::CH_DOT) begin
                phase <= PH_FRAC1;
              end else begin
                state <= S_NEG;
              end
            end else if (phase == PH_FRAC1) begin
              if (is_dig) begin
                acc   <= mac_y;
                phase <= PH_FRAC2;
              end else begin
                state <= S_NEG;
              end
            end else begin
              if (is_dig) begin
                acc <= mac_y;
              end
              state <= S_NEG;
            end
          end
        end

        S_SCALE: begin
          acc   <= mac_y;
          state <= S_NEG;
        end

        S_NEG: begin
          if (neg) begin
            acc <= mac_y;
          end
          state <= S_STORE;
        end

        S_STORE: begin
          if (parsed) begin
            case (term_index)
              2'd0: begin
                pending_head       <= acc;
                pending_time       <= now_q;
                pending_time_valid <= 1'b1;
              end
              2'd1:    pending_pitch <= acc;
              2'd2:    pending_roll  <= acc;
              default: pending_roll  <= pending_roll;
            endcase
          end
          if (ch_q == csp_pkg::CH_LF) begin
            term_length <= '0;
            term_index  <= '0;
            is_angle    <= 1'b0;
            after_cr    <= 1'b0;
          end else begin
            term_length <= '0;
            if (term_index != IDX_MAX) begin
              term_index <= term_index + 1'b1;
            end
            if (ch_q == csp_pkg::CH_CR) begin
              after_cr <= 1'b1;
            end
          end
          state <= S_OUT;
        end

        S_OUT: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            sentence_done <= done_q;
            heading       <= $signed(committed_head);
            pitch         <= $signed(committed_pitch);
            roll          <= $signed(committed_roll);
            has_data      <= committed_time_valid;
            age_ms        <= committed_time_valid ? (now_q - committed_time) : 32'd0;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    term_length <= BUF_LEN_L)
    else $error("term length beyond buffer");

  a_scan_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (pos <= term_length))
    else $error("scan position past term end");

  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> (state == S_SCAN || state == S_SCALE ||
                           state == S_NEG || state == S_STORE))
    else $error("illegal exit from scan");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_OUT))
    else $error("result loaded outside output state");

  a_age_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_data) |-> (age_ms == 32'd0))
    else $error("data age set without data");
`endif

endmodule

FILE: test/tb_compass_sentence_parser_core.sv
// ============================================================================
// tb_compass_sentence_parser_core: self-checking bench for the sentence parser
// Streams characters with millisecond stamps through the parser, predicts
// the committed heading, pitch, roll, has_data and data age of every item,
// and compares each result item with its prediction in arrival order.
// ============================================================================
module tb_compass_sentence_parser_core;

  localparam int TERM_LEN     = 15;
  localparam int N_ITEMS      = 1500;
  localparam int LONG_HOLD    = 300;     // cycles of the long receiver hold-off
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;

  // One item on the input side: a character and its millisecond stamp.
  typedef struct packed {
    logic [7:0]  code;
    logic [31:0] stamp;
  } serial_char_t;

  // One result item as the parser should present it.
  typedef struct packed {
    logic        done;
    logic [31:0] head;
    logic [31:0] pitch;
    logic [31:0] roll;
    logic        has;
    logic [31:0] age;
  } reading_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [7:0]         ch        = 8'h00;
  logic [31:0]        now_ms    = 32'h0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               sentence_done;
  logic signed [31:0] heading;
  logic signed [31:0] pitch;
  logic signed [31:0] roll;
  logic               has_data;
  logic [31:0]        age_ms;

  compass_sentence_parser_core #(
    .TERM_LEN(TERM_LEN)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .ch           (ch),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sentence_done(sentence_done),
    .heading      (heading),
    .pitch        (pitch),
    .roll         (roll),
    .has_data     (has_data),
    .age_ms       (age_ms)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Parser state as the bench tracks it. The term buffer starts undefined;
  // the stimulus never reads a slot that was not written in the same term.
  // --------------------------------------------------------------------------
  logic [7:0]  stored_chars [TERM_LEN-1];
  int          stored_len  = 0;
  int          term_no     = 0;       // saturates at 3
  bit          angle_seen  = 1'b0;    // a decimal point turned up in this sentence
  bit          cr_seen     = 1'b0;    // next terminator commits
  logic [31:0] pend_head   = '0;
  logic [31:0] pend_pitch  = '0;
  logic [31:0] pend_roll   = '0;
  logic [31:0] pend_stamp  = '0;
  bit          pend_ok     = 1'b0;
  logic [31:0] held_head   = '0;
  logic [31:0] held_pitch  = '0;
  logic [31:0] held_roll   = '0;
  logic [31:0] held_stamp  = '0;
  bit          held_ok     = 1'b0;

  serial_char_t chars_to_send [$];
  reading_t     readings_due [$];
  int           chars_offered = 0;
  int           chars_taken   = 0;
  int           readings_seen = 0;
  int           n_errors      = 0;
  int           cycle_count   = 0;
  logic [31:0]  ms_clock      = '0;

  function automatic bit is_digit(input logic [7:0] c);
    return c >= csp_pkg::CH_ZERO && c <= csp_pkg::CH_NINE;
  endfunction

  // Signed decimal in hundredths over the first len buffered characters;
  // every step wraps at 32 bits.
  function automatic logic [31:0] centi_value(input int len);
    logic [31:0] acc;
    int          pos;
    bit          neg;
    acc = '0;
    pos = 0;
    neg = 1'b0;
    if (len > 0 && stored_chars[0] == csp_pkg::CH_MINUS) begin
      neg = 1'b1;
      pos = 1;
    end
    while (pos < len && is_digit(stored_chars[pos])) begin
      acc = acc * 32'd10 + 32'(stored_chars[pos] - csp_pkg::CH_ZERO);
      pos++;
    end
    acc = acc * 32'd100;
    // a point adds at most two fractional digits; a bare point adds nothing
    if (pos + 1 < len && stored_chars[pos] == csp_pkg::CH_DOT &&
        is_digit(stored_chars[pos + 1])) begin
      acc = acc + 32'd10 * 32'(stored_chars[pos + 1] - csp_pkg::CH_ZERO);
      if (pos + 2 < len && is_digit(stored_chars[pos + 2]))
        acc = acc + 32'(stored_chars[pos + 2] - csp_pkg::CH_ZERO);
    end
    return neg ? -acc : acc;
  endfunction

  // Close the running term: commit after a CR, otherwise parse it into the
  // pending slot that its index selects. Returns 1 on a commit.
  function automatic bit close_term(input logic [31:0] now);
    int len;
    if (cr_seen) begin
      held_stamp = pend_stamp;
      held_ok    = pend_ok;
      if (angle_seen) begin
        held_head  = pend_head;
        held_pitch = pend_pitch;
        held_roll  = pend_roll;
      end
      return 1'b1;
    end
    // a NUL byte cuts the term short; a leading NUL leaves nothing to parse
    len = 0;
    while (len < stored_len && stored_chars[len] != csp_pkg::CH_NUL)
      len++;
    if (angle_seen && len > 0) begin
      case (term_no)
        0: begin
          pend_head  = centi_value(len);
          pend_stamp = now;
          pend_ok    = 1'b1;
        end
        1: pend_pitch = centi_value(len);
        2: pend_roll  = centi_value(len);
        default: ;
      endcase
    end
    return 1'b0;
  endfunction

  function automatic void restart_sentence();
    stored_len = 0;
    term_no    = 0;
    angle_seen = 1'b0;
    cr_seen    = 1'b0;
  endfunction

  // Advance the parser by one character and return the result item it owes.
  function automatic reading_t advance_parser(input logic [7:0] c, input logic [31:0] now);
    reading_t r;
    bit       done;
    done = 1'b0;
    if (c == csp_pkg::CH_COMMA || c == csp_pkg::CH_CR || c == csp_pkg::CH_LF) begin
      done = close_term(now);
      if (c == csp_pkg::CH_LF) begin
        restart_sentence();
      end else begin
        // a comma after a CR keeps the CR flag, so it commits again
        if (c == csp_pkg::CH_CR)
          cr_seen = 1'b1;
        if (term_no < 3)
          term_no++;
        stored_len = 0;
      end
    end else if (c == csp_pkg::CH_HASH || c == csp_pkg::CH_STAR) begin
      restart_sentence();
    end else begin
      if (c == csp_pkg::CH_DOT)
        angle_seen = 1'b1;
      // drop anything past the end of the term buffer
      if (stored_len < TERM_LEN - 1) begin
        stored_chars[stored_len] = c;
        stored_len++;
      end
    end
    r.done  = done;
    r.head  = held_head;
    r.pitch = held_pitch;
    r.roll  = held_roll;
    r.has   = held_ok;
    r.age   = held_ok ? now - held_stamp : 32'd0;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus building: every character takes the running millisecond clock,
  // which then creeps forward and now and then jumps to a random value so
  // that every stamp bit and the wrap of the age both get exercised.
  // --------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c);
    chars_to_send.push_back('{c, ms_clock});
    if ($urandom_range(0, 63) == 0)
      ms_clock = $urandom();
    else
      ms_clock = ms_clock + $urandom_range(0, 40);
  endtask

  task automatic send_text(input string s);
    foreach (s[i])
      send_char(s[i]);
  endtask

  function automatic logic [7:0] rand_digit();
    return 8'(csp_pkg::CH_ZERO + $urandom_range(0, 9));
  endfunction

  // One term of a sentence: mostly a signed decimal, sometimes empty,
  // garbage, overlong or cut by a NUL byte.
  task automatic send_term(input bit with_dot);
    int n_dig;
    case ($urandom_range(0, 11))
      0: ;
      1: repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
      2: begin
        repeat ($urandom_range(12, 20)) send_char(rand_digit());
        if (with_dot) begin
          send_char(csp_pkg::CH_DOT);
          repeat ($urandom_range(0, 3)) send_char(rand_digit());
        end
      end
      3: begin
        if ($urandom_range(0, 1))
          send_char(rand_digit());
        send_char(csp_pkg::CH_NUL);
        repeat ($urandom_range(0, 3)) send_char(rand_digit());
      end
      default: begin
        if ($urandom_range(0, 2) == 0)
          send_char(csp_pkg::CH_MINUS);
        n_dig = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 10) : $urandom_range(1, 3);
        repeat (n_dig) send_char(rand_digit());
        if (with_dot) begin
          send_char(csp_pkg::CH_DOT);
          repeat ($urandom_range(0, 3)) send_char(rand_digit());
        end
      end
    endcase
  endtask

  // Idle draw per item; a calm stretch draws no idling at all.
  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer the next character at the falling edge, hold it while the
  // parser stalls, then idle for the cycles drawn for that item.
  // --------------------------------------------------------------------------
  int tx_wait = 0;
  bit tx_calm = 1'b0;

  always @(negedge clk) begin : drive_chars
    serial_char_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || chars_taken == chars_offered) begin
      if (tx_wait > 0) begin
        tx_wait--;
        in_valid <= 1'b0;
      end else if (chars_to_send.size() > 0) begin
        nxt = chars_to_send.pop_front();
        ch       <= nxt.code;
        now_ms   <= nxt.stamp;
        in_valid <= 1'b1;
        chars_offered++;
        if ($urandom_range(0, 39) == 0)
          tx_calm = !tx_calm;
        tx_wait = draw_wait(tx_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall for the cycles drawn after each result item; twice in
  // the run hold off for a long stretch so the parser backs up and stalls
  // the sender.
  // --------------------------------------------------------------------------
  int rx_wait    = 0;
  int rx_counted = 0;
  int holds_done = 0;
  bit rx_calm    = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (readings_seen != rx_counted) begin
        rx_counted = readings_seen;
        if ($urandom_range(0, 39) == 0)
          rx_calm = !rx_calm;
        rx_wait = draw_wait(rx_calm);
      end
      if (holds_done < 2 && chars_taken >= (holds_done == 0 ? 200 : 900)) begin
        rx_wait = LONG_HOLD;
        holds_done++;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check a departing result first, then predict for a character
  // taken at the same edge; a character's result never leaves at the edge
  // that takes it, so the order inside the edge never matters.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("mismatch on %s at item %0d: expected %h, got %h",
                 name, readings_seen, want, got);
    end
  endtask

  always @(posedge clk) begin : watch_ports
    reading_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        readings_seen++;
        if (readings_due.size() == 0) begin
          check_field("out_valid with no item due", 32'd0, 32'd1);
        end else begin
          want = readings_due.pop_front();
          check_field("sentence_done", 32'(want.done), 32'(sentence_done));
          check_field("heading", want.head, heading);
          check_field("pitch", want.pitch, pitch);
          check_field("roll", want.roll, roll);
          check_field("has_data", 32'(want.has), 32'(has_data));
          check_field("age_ms", want.age, age_ms);
        end
      end
      if (in_valid && !in_stall) begin
        readings_due.push_back(advance_parser(ch, now_ms));
        chars_taken++;
      end
    end
  end

  // Guard against a hung parser.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Build the character stream, release reset, wait for the stream to drain.
  // --------------------------------------------------------------------------
  initial begin
    int  n_terms;
    bit  angle;

    // Directed opening. Start on a star, then a negative heading with two
    // fractional digits, a bare point, an empty roll, a fourth term that is
    // never parsed, CR, a second CR that commits, and LF that commits again.
    ms_clock = 32'h0;
    send_text("*-9.05,1.,,Z");
    send_char(csp_pkg::CH_CR);
    send_char(csp_pkg::CH_CR);
    send_char(csp_pkg::CH_LF);
    // Term led by a NUL byte with a top-bit byte inside: nothing parsed.
    // The stamp sits at the top of its range so the age wraps.
    ms_clock = 32'hFFFF_FFFF;
    send_char(csp_pkg::CH_NUL);
    send_text("5.");
    send_char(8'hFF);
    send_char(csp_pkg::CH_COMMA);
    send_char(csp_pkg::CH_HASH);
    // Sentence with no point: commit copies the stamp but keeps the angles.
    send_text("7,");
    send_char(csp_pkg::CH_CR);
    send_char(csp_pkg::CH_COMMA);

    // Random part: mostly well-formed sentences, some noise and broken ends.
    while (chars_to_send.size() < N_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
      end else begin
        angle = $urandom_range(0, 5) != 0;
        if ($urandom_range(0, 3) == 0)
          send_char($urandom_range(0, 1) ? csp_pkg::CH_HASH : csp_pkg::CH_STAR);
        n_terms = $urandom_range(1, 5);
        for (int i = 0; i < n_terms; i++) begin
          send_term(angle && $urandom_range(0, 3) != 0);
          if (i < n_terms - 1)
            send_char(csp_pkg::CH_COMMA);
        end
        case ($urandom_range(0, 7))
          0: ;                         // sentence cut short
          1: send_char(csp_pkg::CH_LF); // LF with no CR: nothing committed
          2: begin                     // CR then restart: commit abandoned
            send_char(csp_pkg::CH_CR);
            send_char(csp_pkg::CH_HASH);
          end
          default: begin
            send_char(csp_pkg::CH_CR);
            if ($urandom_range(0, 3) == 0)
              send_term(1'b1);
            repeat ($urandom_range(0, 2))
              send_char($urandom_range(0, 1) ? csp_pkg::CH_COMMA : csp_pkg::CH_CR);
            send_char(csp_pkg::CH_LF);
          end
        endcase
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for the last character to go in, then for its result item.
    while (chars_to_send.size() != 0 || in_valid)
      @(posedge clk);
    while (readings_due.size() != 0)
      @(posedge clk);
    // Give a stray result item the chance to show itself.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/csp_pkg.sv
hw/rtl/csp_mac.sv
hw/rtl/csp_term_buf.sv
hw/rtl/compass_sentence_parser_core.sv
test/tb_compass_sentence_parser_core.sv
